### rtl/core/ilp_pkg.sv
package ilp_pkg;

  // Parser phase between characters, one-hot
  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_AFTERSIGN = 4'b0010,
    PH_LEADZERO  = 4'b0100,
    PH_DIGITS    = 4'b1000
  } phase_t;

  // Number base of the literal in progress
  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2
  } radix_t;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  // Overflow limits, ceil((2^64-1)/base)
  localparam logic [63:0] LIM_DEC = 64'd1844674407370955162;
  localparam logic [63:0] LIM_HEX = 64'd1152921504606846976;
  localparam logic [63:0] LIM_BIN = 64'd9223372036854775808;

  // Digit index from which the overflow check runs
  localparam logic [7:0] OVF_CHECK_FROM = 8'd16;
  localparam logic [7:0] COUNT_MAX      = 8'd255;

  // Classification of one character
  typedef struct packed {
    logic       is_nul;
    logic       is_minus;
    logic       is_zero;
    logic       is_bin;
    logic       is_dec;
    logic       is_hex;
    logic       is_x;
    logic       is_b;
    logic [3:0] digit;
  } char_class_t;

  // One parse result
  typedef struct packed {
    logic        ok;
    logic [63:0] value;
    logic [7:0]  length;
  } result_t;

endpackage

### rtl/core/ilp_class.sv
module ilp_class (
  input  logic [7:0]           char_code,
  output ilp_pkg::char_class_t cls
);

  logic is_dec;
  logic is_hex;

  // Sort the character into the sets the parser tests
  assign is_dec = char_code inside {[ilp_pkg::CH_ZERO:ilp_pkg::CH_NINE]};
  assign is_hex = char_code inside {[ilp_pkg::CH_LC_A:ilp_pkg::CH_LC_F]};

  always_comb begin
    cls.is_nul   = (char_code == ilp_pkg::CH_NUL);
    cls.is_minus = (char_code == ilp_pkg::CH_MINUS);
    cls.is_zero  = (char_code == ilp_pkg::CH_ZERO);
    cls.is_bin   = (char_code == ilp_pkg::CH_ZERO) || (char_code == ilp_pkg::CH_ONE);
    cls.is_dec   = is_dec;
    cls.is_hex   = is_hex;
    cls.is_x     = (char_code == ilp_pkg::CH_LC_X);
    cls.is_b     = (char_code == ilp_pkg::CH_LC_B);
    // Letters a-f map to 10-15
    if (is_hex) begin
      cls.digit = 4'(char_code - ilp_pkg::CH_LC_A + 8'd10);
    end else begin
      cls.digit = 4'(char_code - ilp_pkg::CH_ZERO);
    end
  end

endmodule

### rtl/core/ilp_engine.sv
module ilp_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 first,
  input  ilp_pkg::char_class_t cls,
  output logic                 res_valid,
  output ilp_pkg::result_t     res
);

  ilp_pkg::phase_t phase, phase_next;
  ilp_pkg::radix_t radix_sel, radix_sel_next;
  logic        negative, negative_next;
  logic [63:0] acc_main, acc_main_next;
  logic [63:0] acc_hex_shadow, acc_hex_shadow_next;
  logic        overflow_main, overflow_main_next;
  logic        overflow_hex, overflow_hex_next;
  logic [7:0]  digit_count, digit_count_next;
  logic [1:0]  lead_chars, lead_chars_next;

  logic        go_digits;
  logic        add;
  logic        fin;
  logic [3:0]  dval;
  logic [63:0] lim;
  logic [63:0] acc_sel;
  logic        bad;
  logic [8:0]  len_sum;

  // Work out the state after this character and any result it ends with
  always_comb begin
    // Start from the held literal, or a cleared one on restart
    if (first) begin
      phase_next          = ilp_pkg::PH_IDLE;
      radix_sel_next      = ilp_pkg::RX_DEC;
      negative_next       = 1'b0;
      acc_main_next       = '0;
      acc_hex_shadow_next = '0;
      overflow_main_next  = 1'b0;
      overflow_hex_next   = 1'b0;
      digit_count_next    = '0;
      lead_chars_next     = '0;
    end else begin
      phase_next          = phase;
      radix_sel_next      = radix_sel;
      negative_next       = negative;
      acc_main_next       = acc_main;
      acc_hex_shadow_next = acc_hex_shadow;
      overflow_main_next  = overflow_main;
      overflow_hex_next   = overflow_hex;
      digit_count_next    = digit_count;
      lead_chars_next     = lead_chars;
    end
    go_digits = 1'b0;
    add       = 1'b0;
    fin       = 1'b0;
    dval      = cls.digit;
    res_valid = 1'b0;
    res       = '0;
    lim       = ilp_pkg::LIM_DEC;
    acc_sel   = '0;
    bad       = 1'b0;
    len_sum   = '0;

    if (step) begin
      if (first && cls.is_nul) begin
        // Empty input: failed result with zero payload
        res_valid = 1'b1;
      end else if (first) begin
        if (cls.is_minus) begin
          negative_next   = 1'b1;
          lead_chars_next = 2'd1;
          phase_next      = ilp_pkg::PH_AFTERSIGN;
        end else if (cls.is_zero) begin
          add        = 1'b1;
          phase_next = ilp_pkg::PH_LEADZERO;
        end else begin
          go_digits = 1'b1;
        end
      end else begin
        case (phase)
          ilp_pkg::PH_IDLE: begin
            go_digits = 1'b0;
          end
          ilp_pkg::PH_AFTERSIGN: begin
            if (cls.is_zero) begin
              add        = 1'b1;
              phase_next = ilp_pkg::PH_LEADZERO;
            end else begin
              go_digits = 1'b1;
            end
          end
          ilp_pkg::PH_LEADZERO: begin
            if (cls.is_x || cls.is_b) begin
              radix_sel_next      = cls.is_x ? ilp_pkg::RX_HEX : ilp_pkg::RX_BIN;
              lead_chars_next     = lead_chars + 2'd2;
              digit_count_next    = '0;
              acc_main_next       = '0;
              acc_hex_shadow_next = '0;
              overflow_main_next  = 1'b0;
              overflow_hex_next   = 1'b0;
              phase_next          = ilp_pkg::PH_DIGITS;
            end else begin
              go_digits = 1'b1;
            end
          end
          ilp_pkg::PH_DIGITS: begin
            go_digits = 1'b1;
          end
          default: begin
            go_digits = 1'b0;
          end
        endcase
      end

      // Digit body: take a digit or end the literal
      if (go_digits) begin
        phase_next = ilp_pkg::PH_DIGITS;
        if (radix_sel_next == ilp_pkg::RX_BIN) begin
          if (cls.is_bin) begin
            add = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end else if (cls.is_dec || cls.is_hex) begin
          if (cls.is_hex) begin
            radix_sel_next = ilp_pkg::RX_HEX;
          end
          add = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end

      // Accumulate one digit in both bases, checking overflow first
      if (add) begin
        lim = (radix_sel_next == ilp_pkg::RX_BIN) ? ilp_pkg::LIM_BIN : ilp_pkg::LIM_DEC;
        if (digit_count_next >= ilp_pkg::OVF_CHECK_FROM) begin
          if (acc_main_next >= lim) begin
            overflow_main_next = 1'b1;
          end
          if (acc_hex_shadow_next >= ilp_pkg::LIM_HEX) begin
            overflow_hex_next = 1'b1;
          end
        end
        acc_hex_shadow_next = {acc_hex_shadow_next[59:0], dval};
        case (radix_sel_next)
          ilp_pkg::RX_DEC: begin
            acc_main_next = {acc_main_next[60:0], 3'b000} + {acc_main_next[62:0], 1'b0}
                            + {60'd0, dval};
          end
          ilp_pkg::RX_BIN: begin
            acc_main_next = {acc_main_next[62:0], dval[0]};
          end
          default: begin
            acc_main_next = acc_main_next;
          end
        endcase
        if (digit_count_next != ilp_pkg::COUNT_MAX) begin
          digit_count_next = digit_count_next + 8'd1;
        end
      end

      // End of literal: pick the base and emit the result
      if (fin) begin
        phase_next = ilp_pkg::PH_IDLE;
        res_valid  = 1'b1;
        if (radix_sel_next == ilp_pkg::RX_HEX) begin
          acc_sel = acc_hex_shadow_next;
          bad     = overflow_hex_next;
        end else begin
          acc_sel = acc_main_next;
          bad     = overflow_main_next;
        end
        len_sum = {1'b0, digit_count_next} + {7'd0, lead_chars_next};
        if (!bad) begin
          res.ok     = 1'b1;
          res.value  = negative_next ? (64'd0 - acc_sel) : acc_sel;
          res.length = len_sum[8] ? ilp_pkg::COUNT_MAX : len_sum[7:0];
        end
      end
    end
  end

  // Hold the literal state between characters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ilp_pkg::PH_IDLE;
      radix_sel      <= ilp_pkg::RX_DEC;
      negative       <= 1'b0;
      acc_main       <= '0;
      acc_hex_shadow <= '0;
      overflow_main  <= 1'b0;
      overflow_hex   <= 1'b0;
      digit_count    <= '0;
      lead_chars     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      radix_sel      <= radix_sel_next;
      negative       <= negative_next;
      acc_main       <= acc_main_next;
      acc_hex_shadow <= acc_hex_shadow_next;
      overflow_main  <= overflow_main_next;
      overflow_hex   <= overflow_hex_next;
      digit_count    <= digit_count_next;
      lead_chars     <= lead_chars_next;
    end
  end

endmodule

### rtl/core/integer_literal_parser_top.sv
// Integer literal parser: decimal, hex ("0x") and binary ("0b"), optional '-'.
// Input channel s_*: one character per word, tdata[7:0] = char_code,
//   tuser = first (restarts the parser on this character).
// Output channel m_*: one word per finished literal, tdata[63:0] = value,
//   tdata[71:64] = length, tuser = ok.
// A literal ends on the first character that does not belong to it (NUL
//   included); that character yields the output word. Characters inside a
//   literal, or after it has ended without a new first, yield nothing.
// Path: the ending character waits in the input register; its result word
//   loads into the result register once that register is free to take a
//   word.
// Throughput: one character per cycle while the result register can take a
//   word; the per-character update of both accumulators is a single
//   shift-and-add pass between the input register and the literal state.
// Reset clears both registers and the literal state; the parser waits for a
//   word with first set. When the receiver stalls, the result word holds and
//   the input register still advances while the result register is free;
//   once both are full, s_tready falls until the result word is taken.
module integer_literal_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tuser,   // [0] first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [63:0] value, [71:64] length
  output logic        m_tuser    // [0] ok
);

  logic                 in_vld;
  logic [7:0]           in_char;
  logic                 in_first;
  logic                 advance;
  logic                 out_vld;
  ilp_pkg::result_t     out_res;
  ilp_pkg::char_class_t cls;
  logic                 res_valid;
  ilp_pkg::result_t     res;

  // Process the held word when the result register can take a word
  assign advance  = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  ilp_class u_class (
    .char_code (in_char),
    .cls       (cls)
  );

  ilp_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .first     (in_first),
    .cls       (cls),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: load on a finished literal, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance && res_valid) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {out_res.length, out_res.value};
  assign m_tuser  = out_res.ok;

`ifndef SYNTHESIS
  // A failed literal carries zero value and length
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == 72'd0))
    else $error("failed result with non-zero payload");

  // A zero-length literal has value zero
  a_len0_val0: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && (m_tdata[71:64] == 8'd0)) |-> (m_tdata[63:0] == 64'd0))
    else $error("zero-length literal with non-zero value");

  // A held character is never lost while the result side is blocked
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !advance) |=> in_vld)
    else $error("held character dropped");
`endif

endmodule

### tb/integer_literal_parser_top_tb.sv
module integer_literal_parser_top_tb;

  // Parser position within a literal
  typedef enum logic [2:0] {
    LP_WAIT,
    LP_OPEN,
    LP_SIGNED,
    LP_ZERO,
    LP_BODY
  } lit_phase_t;

  // One character word waiting to be sent
  typedef struct {
    logic [7:0] ch;
    logic       first;
    bit         drain;
  } char_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] char_code
  logic        s_tuser = 1'b0;    // [0] first
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;           // [63:0] value, [71:64] length
  logic        m_tuser;           // [0] ok

  char_item_t       text_q[$];
  ilp_pkg::result_t parsed_q[$];
  int          errors = 0;
  int          chars_sent = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic        calm;

  // Predictor state for the literal in progress
  lit_phase_t      lit_phase = LP_WAIT;
  logic            lit_neg = 1'b0;
  ilp_pkg::radix_t lit_radix = ilp_pkg::RX_DEC;
  logic [63:0] acc_main = '0;
  logic [63:0] acc_hex = '0;
  logic        ovf_main = 1'b0;
  logic        ovf_hex = 1'b0;
  logic [7:0]  ndigits = '0;
  logic [1:0]  nlead = '0;

  integer_literal_parser_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // No idling on either side while this window of characters goes through
  assign calm = (chars_sent >= 500) && (chars_sent < 700);

  // Fold one digit into both accumulators, checking overflow from the 17th digit on
  function automatic void push_digit(input logic [3:0] d);
    logic [63:0] lim;
    lim = (lit_radix == ilp_pkg::RX_BIN) ? ilp_pkg::LIM_BIN : ilp_pkg::LIM_DEC;
    if (ndigits >= ilp_pkg::OVF_CHECK_FROM) begin
      if (acc_main >= lim) ovf_main = 1'b1;
      if (acc_hex >= ilp_pkg::LIM_HEX) ovf_hex = 1'b1;
    end
    acc_hex = {acc_hex[59:0], 4'h0} + 64'(d);
    if (lit_radix == ilp_pkg::RX_DEC) acc_main = acc_main * 64'd10 + 64'(d);
    else if (lit_radix == ilp_pkg::RX_BIN) acc_main = {acc_main[62:0], 1'b0} + 64'(d);
    if (ndigits != ilp_pkg::COUNT_MAX) ndigits = ndigits + 8'd1;
  endfunction

  // End the literal and form its result word
  function automatic ilp_pkg::result_t close_literal();
    ilp_pkg::result_t r;
    logic [63:0] mag;
    logic        bad;
    logic [8:0]  len;
    mag = (lit_radix == ilp_pkg::RX_HEX) ? acc_hex : acc_main;
    bad = (lit_radix == ilp_pkg::RX_HEX) ? ovf_hex : ovf_main;
    len = 9'(nlead) + 9'(ndigits);
    r = '0;
    if (!bad) begin
      r.ok = 1'b1;
      r.value = lit_neg ? 64'd0 - mag : mag;
      r.length = (len > 9'd255) ? 8'd255 : len[7:0];
    end
    lit_phase = LP_WAIT;
    return r;
  endfunction

  // Advance the parser by one character; return 1 when a result word is due
  function automatic bit parse_char(input logic [7:0] ch, input logic first,
                                    output ilp_pkg::result_t r);
    logic is_dec;
    logic is_hex;
    r = '0;
    if (first) begin
      lit_phase = LP_WAIT;
      lit_neg = 1'b0;
      lit_radix = ilp_pkg::RX_DEC;
      acc_main = '0;
      acc_hex = '0;
      ovf_main = 1'b0;
      ovf_hex = 1'b0;
      ndigits = '0;
      nlead = '0;
      if (ch == ilp_pkg::CH_NUL) return 1'b1;
      lit_phase = LP_OPEN;
    end
    if (lit_phase == LP_WAIT) return 1'b0;
    if (lit_phase == LP_OPEN) begin
      lit_phase = LP_SIGNED;
      if (ch == ilp_pkg::CH_MINUS) begin
        lit_neg = 1'b1;
        nlead = 2'd1;
        return 1'b0;
      end
    end
    if (lit_phase == LP_SIGNED) begin
      if (ch == ilp_pkg::CH_ZERO) begin
        push_digit(4'd0);
        lit_phase = LP_ZERO;
        return 1'b0;
      end
      lit_phase = LP_BODY;
    end
    if (lit_phase == LP_ZERO) begin
      lit_phase = LP_BODY;
      // "0x" and "0b" always select the base and restart the digits
      if (ch == ilp_pkg::CH_LC_X || ch == ilp_pkg::CH_LC_B) begin
        lit_radix = (ch == ilp_pkg::CH_LC_X) ? ilp_pkg::RX_HEX : ilp_pkg::RX_BIN;
        nlead = nlead + 2'd2;
        ndigits = '0;
        acc_main = '0;
        acc_hex = '0;
        ovf_main = 1'b0;
        ovf_hex = 1'b0;
        return 1'b0;
      end
    end
    is_dec = (ch >= ilp_pkg::CH_ZERO) && (ch <= ilp_pkg::CH_NINE);
    is_hex = (ch >= ilp_pkg::CH_LC_A) && (ch <= ilp_pkg::CH_LC_F);
    if (lit_radix == ilp_pkg::RX_BIN) begin
      if (ch == ilp_pkg::CH_ZERO || ch == ilp_pkg::CH_ONE) begin
        push_digit(ch[3:0]);
        return 1'b0;
      end
      r = close_literal();
      return 1'b1;
    end
    // First lowercase a-f turns a decimal literal into hex
    if (lit_radix == ilp_pkg::RX_DEC && is_hex) lit_radix = ilp_pkg::RX_HEX;
    if (is_dec) begin
      push_digit(ch[3:0]);
      return 1'b0;
    end
    if (is_hex && lit_radix == ilp_pkg::RX_HEX) begin
      push_digit(ch[3:0] + 4'd9);
      return 1'b0;
    end
    r = close_literal();
    return 1'b1;
  endfunction

  task automatic put_char(input logic [7:0] ch, input logic first, input bit drain = 1'b0);
    char_item_t it;
    it.ch = ch;
    it.first = first;
    it.drain = drain;
    text_q.push_back(it);
  endtask

  // Queue a literal text followed by the character that ends it
  task automatic put_literal(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) put_char(s[i], i == 0);
    put_char(term, s.len() == 0);
  endtask

  function automatic logic [7:0] rand_digit(input int base);
    int v;
    if (base == 2) return 8'(ilp_pkg::CH_ZERO + $urandom_range(1));
    if (base == 1) begin
      v = $urandom_range(15);
      return (v < 10) ? 8'(ilp_pkg::CH_ZERO + v) : 8'(ilp_pkg::CH_LC_A + v - 10);
    end
    if ($urandom_range(11) == 0) return 8'(ilp_pkg::CH_LC_A + $urandom_range(5));
    return 8'(ilp_pkg::CH_ZERO + $urandom_range(9));
  endfunction

  // Mostly well-formed literals with random content, plus empty and garbage ones
  task automatic put_random_literal(input bit drain, inout int useful);
    logic [7:0] body[$];
    string      bound;
    int         kind;
    int         base;
    int         ndig;
    int         pick;
    kind = $urandom_range(99);
    if (kind < 4) begin
      body.push_back(ilp_pkg::CH_NUL);
    end else if (kind < 12) begin
      repeat ($urandom_range(4, 1)) body.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) == 0) body.push_back(ilp_pkg::CH_MINUS);
      base = $urandom_range(2);
      if (base != 0) begin
        body.push_back(ilp_pkg::CH_ZERO);
        body.push_back((base == 1) ? ilp_pkg::CH_LC_X : ilp_pkg::CH_LC_B);
      end
      pick = $urandom_range(99);
      if (pick < 75) ndig = $urandom_range(8);
      else if (base == 0) ndig = $urandom_range(21, 18);
      else if (base == 1) ndig = $urandom_range(18, 15);
      else ndig = $urandom_range(66, 62);
      // Decimal values either side of the overflow limit
      if (base == 0 && pick >= 95) begin
        bound = $urandom_range(1) ? "1844674407370955161" : "1844674407370955162";
        for (int i = 0; i < bound.len(); i++) body.push_back(bound[i]);
        ndig = 1;
      end
      repeat (ndig) body.push_back(rand_digit(base));
      case ($urandom_range(7))
        0: body.push_back(ilp_pkg::CH_NUL);
        1: body.push_back(8'h20);
        2: body.push_back(8'($urandom_range(255)));
        3: body.push_back(8'($urandom_range(8'h5A, 8'h41)));
        4: body.push_back(8'($urandom_range(8'h7A, 8'h67)));
        5: ; // left open: the next first word drops it
        default: body.push_back(ilp_pkg::CH_NUL);
      endcase
    end
    foreach (body[i]) put_char(body[i], i == 0, drain && i == 0);
    useful += body.size();
    // Stray words after the end of a literal
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(3, 1)) put_char(8'($urandom_range(255)), 1'b0);
  endtask

  // Sender: offer queued words, predict each accepted one
  always @(posedge clk) begin
    ilp_pkg::result_t res;
    bit      due;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        due = parse_char(s_tdata, s_tuser, res);
        if (due) parsed_q.push_back(res);
        void'(text_q.pop_front());
        chars_sent <= chars_sent + 1;
      end
      // Hold the word while it waits; otherwise pick the next or idle
      if (!s_tvalid || s_tready) begin
        if (text_q.size() != 0 && (calm || $urandom_range(99) >= 24) &&
            !(text_q[0].drain && parsed_q.size() != 0)) begin
          s_tvalid <= 1'b1;
          s_tdata <= text_q[0].ch;
          s_tuser <= text_q[0].first;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Receiver: compare each result word with the oldest prediction
  always @(posedge clk) begin
    ilp_pkg::result_t want;
    logic    rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (parsed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ok %0b value %h length %0d",
                   $time, m_tuser, m_tdata[63:0], m_tdata[71:64]);
          errors++;
        end else begin
          want = parsed_q.pop_front();
          check_field("ok", 64'(m_tuser), 64'(want.ok));
          check_field("value", m_tdata[63:0], want.value);
          check_field("length", 64'(m_tdata[71:64]), 64'(want.length));
        end
      end
      // One long hold-off so the parser fills up and stalls its input
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && results_seen == 30) begin
        hold_left = 80;
        hold_done = 1'b1;
        rdy = 1'b0;
      end else begin
        rdy = calm || ($urandom_range(99) >= 24);
      end
      m_tready <= rdy;
    end
  end

  initial begin
    int useful;
    int lit;
    // Directed literals
    put_literal("", ilp_pkg::CH_NUL);
    put_literal("-", ilp_pkg::CH_NUL);
    put_literal("0x", 8'h20);
    put_literal("-0b", ",");
    put_literal("0b101", "2");
    put_literal("", "z");
    put_char("9", 1'b0);
    put_char(8'hFF, 1'b0);
    put_literal("1234", 8'hFF);
    put_literal("-12ab", "A");
    put_literal("9f", "F");
    put_char("9", 1'b1);
    put_char("8", 1'b0);
    put_literal("0xff", ilp_pkg::CH_NUL);
    put_literal("-0", ilp_pkg::CH_NUL);
    put_literal("00", 8'h2E);
    put_literal("0xf", "g");
    put_literal("18446744073709551615", ilp_pkg::CH_NUL);
    put_literal("-9223372036854775808", ilp_pkg::CH_NUL);
    put_literal("18446744073709551620", ilp_pkg::CH_NUL);
    put_char(ilp_pkg::CH_NUL, 1'b1, 1'b1);
    put_literal("0x10000000000000000", ilp_pkg::CH_NUL);
    put_literal("-0b1010", ilp_pkg::CH_NUL);

    // Random literals
    useful = 0;
    lit = 0;
    while (useful < 1050) begin
      if (lit == 40) begin
        // Length saturates: prefix plus 256 digits, leading zeros keep it valid
        put_char(ilp_pkg::CH_ZERO, 1'b1);
        put_char(ilp_pkg::CH_LC_X, 1'b0);
        repeat (255) put_char(ilp_pkg::CH_ZERO, 1'b0);
        put_char("7", 1'b0);
        put_char(ilp_pkg::CH_NUL, 1'b0);
        useful += 259;
      end else begin
        put_random_literal(lit == 0 || lit == 80, useful);
      end
      lit++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (text_q.size() != 0 || s_tvalid) @(posedge clk);
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
